/* rtl/core/dfid_pkg.sv */
`timescale 1ns / 1ps

package dfid_pkg;

	// Default field buffer sizes (one byte of each is reserved, as in a C string)
	localparam int DEC_FIELD_BYTES_DEF = 64;
	localparam int B62_FIELD_BYTES_DEF = 128;

	// Configuration register indexes
	localparam logic [1:0] CFG_SEPARATOR = 2'd0;
	localparam logic [1:0] CFG_WANTED    = 2'd1;
	localparam logic [1:0] CFG_FORMAT    = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0] SEPARATOR_RST = 8'h7C;
	localparam logic [7:0] WANTED_RST    = 8'd1;

	// Number formats
	localparam logic FMT_DECIMAL = 1'b0;
	localparam logic FMT_BASE62  = 1'b1;

	// Field status codes
	localparam logic [1:0] ST_MISSING = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_BYTES   = 2'd2;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	typedef enum logic [2:0] {
		PH_SKIP = 3'b001,
		PH_TAKE = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		DS_LEAD = 3'b001,
		DS_DIG  = 3'b010,
		DS_STOP = 3'b100
	} dstage_t;

endpackage

/* rtl/core/delimited_field_integer_decoder.sv */
`timescale 1ns / 1ps

// Delimited field integer decoder.
// Input channel: one transaction per record byte (data_byte, end_of_record = 0),
// then one terminator transaction (end_of_record = 1, data_byte ignored).
// Output channel: one transaction per terminator, carrying decoded_value and
// field_status (missing / empty / has bytes). Data bytes give no transaction.
// Throughput: one input transaction per cycle while in_stall is low. Each byte
// is held in an input register and folded into the field state in the next
// cycle by a compare and a constant multiply-add (x10 or x62), so that path
// sets the rate. A terminator passes from the input register into the result
// register once that register holds no stalled result, and waits there until taken.
// Stall: the result register holds its value while out_stall is high. A later
// terminator then waits in the input register and raises in_stall; data
// bytes keep flowing, so in_stall only rises behind a stalled result.
// Reset (arst_n low): registers return to separator '|', field one, decimal
// format; record state restarts and both channels come up empty.
// A write to one of the three registers takes effect at once and restarts the
// record; a write to the unused index changes nothing.
module delimited_field_integer_decoder #(
	parameter int DECIMAL_FIELD_BYTES = dfid_pkg::DEC_FIELD_BYTES_DEF,
	parameter int BASE62_FIELD_BYTES  = dfid_pkg::B62_FIELD_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_record,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] decoded_value,
	output logic [1:0]         field_status,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	// Counter width covers the longer field buffer
	localparam int MAX_BYTES = (DECIMAL_FIELD_BYTES > BASE62_FIELD_BYTES) ?
		DECIMAL_FIELD_BYTES : BASE62_FIELD_BYTES;
	localparam int CNT_W = $clog2(MAX_BYTES);
	localparam logic [CNT_W:0] DEC_LIMIT = (CNT_W + 1)'(DECIMAL_FIELD_BYTES);
	localparam logic [CNT_W:0] B62_LIMIT = (CNT_W + 1)'(BASE62_FIELD_BYTES);

	// Configuration registers
	logic [7:0] sep_q;
	logic [7:0] wanted_q;
	logic       fmt_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eor_s1;

	// Record state
	logic [7:0]       fc_q;
	dfid_pkg::phase_t phase_q;
	logic             trail_q;
	logic [CNT_W-1:0] taken_q;
	logic             seen_q;
	logic [31:0]      acc_q;
	logic             neg_q;
	dfid_pkg::dstage_t dstage_q;

	// Next record state
	logic [7:0]       fc_d;
	dfid_pkg::phase_t phase_d;
	logic             trail_d;
	logic [CNT_W-1:0] taken_d;
	logic             seen_d;
	logic [31:0]      acc_d;
	logic             neg_d;
	dfid_pkg::dstage_t dstage_d;

	// Output register
	logic        out_valid_q;
	logic [31:0] value_q;
	logic [1:0]  status_q;

	logic        advance;
	logic        accept;
	logic        cfg_hit;
	logic        restart;
	logic [7:0]  wanted_next;
	logic [7:0]  fc_inc;
	logic [CNT_W:0] limit;
	logic [CNT_W:0] taken_ext;
	logic        do_take;
	logic [31:0] acc_x10;
	logic [31:0] acc_x62;
	logic [31:0] missing_val;
	logic [31:0] result_val;
	logic [1:0]  result_st;
	logic        is_dig;
	logic        is_low;
	logic        is_up;

	// A terminator can only leave the input register when the result slot frees
	assign advance  = valid_s1 && !(eor_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && eor_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign out_valid     = out_valid_q;
	assign decoded_value = value_q;
	assign field_status  = status_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q    <= dfid_pkg::SEPARATOR_RST;
			wanted_q <= dfid_pkg::WANTED_RST;
			fmt_q    <= dfid_pkg::FMT_DECIMAL;
		end else if (cfg_we) begin
			case (cfg_index)
				dfid_pkg::CFG_SEPARATOR: sep_q    <= cfg_data;
				dfid_pkg::CFG_WANTED:    wanted_q <= cfg_data;
				dfid_pkg::CFG_FORMAT:    fmt_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Only a write that lands in a real register restarts the record
	assign cfg_hit = cfg_we && (cfg_index == dfid_pkg::CFG_SEPARATOR ||
		cfg_index == dfid_pkg::CFG_WANTED || cfg_index == dfid_pkg::CFG_FORMAT);

	// Field index that the restarted record will use
	assign wanted_next = (cfg_we && cfg_index == dfid_pkg::CFG_WANTED) ? cfg_data : wanted_q;
	assign restart     = cfg_hit || (advance && eor_s1);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			eor_s1  <= end_of_record;
		end
	end

	assign fc_inc      = fc_q + 8'd1;
	assign limit       = fmt_q ? B62_LIMIT : DEC_LIMIT;
	assign taken_ext   = {1'b0, taken_q};
	assign acc_x10     = acc_q * 32'd10;
	assign acc_x62     = acc_q * 32'd62;
	assign missing_val = fmt_q ? 32'hFFFF_FFFF : 32'd0;
	assign is_dig      = byte_s1 >= dfid_pkg::CH_ZERO && byte_s1 <= dfid_pkg::CH_NINE;
	assign is_low      = byte_s1 >= dfid_pkg::CH_LA && byte_s1 <= dfid_pkg::CH_LZ;
	assign is_up       = byte_s1 >= dfid_pkg::CH_UA && byte_s1 <= dfid_pkg::CH_UZ;

	// Field scan: skip to the wanted field, then take bytes up to the limit
	always_comb begin
		fc_d    = fc_q;
		phase_d = phase_q;
		trail_d = trail_q;
		seen_d  = seen_q;
		do_take = 1'b0;
		case (phase_q)
			dfid_pkg::PH_SKIP: begin
				if (trail_q) begin
					trail_d = 1'b0;
				end else if (!byte_s1[7]) begin
					if (byte_s1 == sep_q) begin
						fc_d = fc_inc;
						if (fc_inc >= wanted_q) phase_d = dfid_pkg::PH_TAKE;
					end
				end else begin
					trail_d = 1'b1;
				end
			end
			dfid_pkg::PH_TAKE: begin
				seen_d = 1'b1;
				if (trail_q) begin
					trail_d = 1'b0;
					do_take = 1'b1;
				end else if (!byte_s1[7]) begin
					if (byte_s1 == sep_q) phase_d = dfid_pkg::PH_DONE;
					else do_take = 1'b1;
				end else if (taken_ext + (CNT_W + 1)'(2) >= limit) begin
					// lead byte and its trail do not both fit: close the field
					phase_d = dfid_pkg::PH_DONE;
				end else begin
					do_take = 1'b1;
					trail_d = 1'b1;
				end
			end
			default: ;
		endcase
		if (do_take && taken_ext + (CNT_W + 1)'(2) >= limit) phase_d = dfid_pkg::PH_DONE;
	end

	assign taken_d = do_take ? taken_q + CNT_W'(1) : taken_q;

	// Digit decoder for a taken byte
	always_comb begin
		acc_d    = acc_q;
		neg_d    = neg_q;
		dstage_d = dstage_q;
		if (do_take && dstage_q != dfid_pkg::DS_STOP) begin
			if (fmt_q == dfid_pkg::FMT_DECIMAL) begin
				if (dstage_q == dfid_pkg::DS_LEAD &&
						(byte_s1 == dfid_pkg::CH_SPACE || byte_s1 == dfid_pkg::CH_TAB)) begin
					// skip leading whitespace
				end else if (dstage_q == dfid_pkg::DS_LEAD && byte_s1 == dfid_pkg::CH_MINUS) begin
					dstage_d = dfid_pkg::DS_DIG;
					neg_d    = 1'b1;
				end else if (dstage_q == dfid_pkg::DS_LEAD && byte_s1 == dfid_pkg::CH_PLUS) begin
					dstage_d = dfid_pkg::DS_DIG;
				end else if (is_dig) begin
					dstage_d = dfid_pkg::DS_DIG;
					acc_d    = acc_x10 + {24'd0, byte_s1 - dfid_pkg::CH_ZERO};
				end else begin
					dstage_d = dfid_pkg::DS_STOP;
				end
			end else begin
				if (is_dig) begin
					acc_d = acc_x62 + {24'd0, byte_s1 - dfid_pkg::CH_ZERO};
				end else if (is_low) begin
					acc_d = acc_x62 + {24'd0, byte_s1 - dfid_pkg::CH_LA + 8'd10};
				end else if (is_up) begin
					acc_d = acc_x62 + {24'd0, byte_s1 - dfid_pkg::CH_UA + 8'd36};
				end else if (byte_s1 == dfid_pkg::CH_MINUS) begin
					neg_d = 1'b1;
				end else begin
					dstage_d = dfid_pkg::DS_STOP;
				end
			end
		end
	end

	// Result of a terminator
	always_comb begin
		if (phase_q == dfid_pkg::PH_SKIP) begin
			// a lone lead byte while skipping counts as a field with bytes
			result_val = trail_q ? 32'd0 : missing_val;
			result_st  = trail_q ? dfid_pkg::ST_BYTES : dfid_pkg::ST_MISSING;
		end else if (!seen_q) begin
			result_val = missing_val;
			result_st  = dfid_pkg::ST_MISSING;
		end else if (taken_q == '0) begin
			result_val = missing_val;
			result_st  = dfid_pkg::ST_EMPTY;
		end else begin
			result_val = neg_q ? 32'd0 - acc_q : acc_q;
			result_st  = dfid_pkg::ST_BYTES;
		end
	end

	// Record state: restart on a terminator or a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q     <= 8'd1;
			phase_q  <= (dfid_pkg::WANTED_RST <= 8'd1) ? dfid_pkg::PH_TAKE : dfid_pkg::PH_SKIP;
			trail_q  <= 1'b0;
			taken_q  <= '0;
			seen_q   <= 1'b0;
			acc_q    <= 32'd0;
			neg_q    <= 1'b0;
			dstage_q <= dfid_pkg::DS_LEAD;
		end else if (restart) begin
			fc_q     <= 8'd1;
			phase_q  <= (wanted_next <= 8'd1) ? dfid_pkg::PH_TAKE : dfid_pkg::PH_SKIP;
			trail_q  <= 1'b0;
			taken_q  <= '0;
			seen_q   <= 1'b0;
			acc_q    <= 32'd0;
			neg_q    <= 1'b0;
			dstage_q <= dfid_pkg::DS_LEAD;
		end else if (advance) begin
			fc_q     <= fc_d;
			phase_q  <= phase_d;
			trail_q  <= trail_d;
			taken_q  <= taken_d;
			seen_q   <= seen_d;
			acc_q    <= acc_d;
			neg_q    <= neg_d;
			dstage_q <= dstage_d;
		end
	end

	// Result register: load on a terminator, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eor_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eor_s1) begin
			value_q  <= result_val;
			status_q <= result_st;
		end
	end

endmodule

/* rtl/core/dfid_checker.sv */
`timescale 1ns / 1ps

module dfid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        end_of_record,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] decoded_value,
	input logic [1:0]  field_status
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(decoded_value) && $stable(field_status))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_status == dfid_pkg::ST_MISSING ||
			field_status == dfid_pkg::ST_EMPTY || field_status == dfid_pkg::ST_BYTES)
		else $error("bad field status code");

	// A new result comes from an accepted terminator, through the input and result registers
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && end_of_record, 2))
		else $error("result without terminator");

	// Input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule

bind delimited_field_integer_decoder dfid_checker u_dfid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.end_of_record (end_of_record),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.decoded_value (decoded_value),
	.field_status  (field_status)
);
